@@ design/pcab_pkg.sv @@
`default_nettype none

package pcab_pkg;

    // Fixed sizes of the configuration space and the register file.
    localparam int SPACE_BYTES = 256;
    localparam int MAX_SLOTS   = 4;
    localparam int BDF_W       = 9;
    localparam int PADDR_W     = 5;
    localparam int PDATA_W     = 32;

    // Reserved bits of the address latch, cleared after every address byte write.
    localparam logic [31:0] RESERVED_ADDR_BITS = 32'h7F00_0003;

    // Item command codes.
    localparam logic [1:0] CMD_READ  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_STORE = 2'd2;

    // Access size codes; any other code means four bytes.
    localparam logic [1:0] SIZE_BYTE = 2'd0;
    localparam logic [1:0] SIZE_WORD = 2'd1;

    // Register indexes on the configuration port.
    localparam logic [2:0] REG_SLOT0_BDF     = 3'd0;
    localparam logic [2:0] REG_SLOT1_BDF     = 3'd1;
    localparam logic [2:0] REG_SLOT2_BDF     = 3'd2;
    localparam logic [2:0] REG_SLOT3_BDF     = 3'd3;
    localparam logic [2:0] REG_SLOT_PRESENT  = 3'd4;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [2:0]  port_offset;
        logic [1:0]  access_size;
        logic [31:0] write_data;
        logic [1:0]  store_slot;
        logic [7:0]  store_offset;
    } in_item_t;

    typedef struct packed {
        logic [31:0] read_data;
        logic        range_error;
    } out_item_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       clear;
        logic       load_item;
        logic       step;
        logic [1:0] step_idx;
        logic       load_out;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic       clear_last;
        logic [2:0] item_steps;
    } dp_status_t;

endpackage

`default_nettype wire

@@ design/pcab_ram.sv @@
`default_nettype none

module pcab_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     en,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata <= mem[addr];
            end
        end
    end

endmodule

`default_nettype wire

@@ design/pcab_ctrl.sv @@
`default_nettype none

module pcab_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output pcab_pkg::dp_cmd_t         cmd,
    input  wire pcab_pkg::dp_status_t status
);

    import pcab_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_STEP  = 4'b0100,
        S_FIN   = 4'b1000
    } state_t;

    state_t     state_reg;
    state_t     state_next;
    logic [2:0] steps_reg;
    logic [2:0] steps_next;
    logic [1:0] step_idx_reg;
    logic [1:0] step_idx_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    always_comb
    begin
        state_next    = state_reg;
        steps_next    = steps_reg;
        step_idx_next = step_idx_reg;
        in_ready      = 1'b0;
        cmd           = '0;
        cmd.step_idx  = step_idx_reg;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (status.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    steps_next    = status.item_steps;
                    step_idx_next = 2'd0;
                    state_next    = (status.item_steps == 3'd0) ? S_FIN : S_STEP;
                end
            end
            S_STEP:
            begin
                cmd.step      = 1'b1;
                step_idx_next = step_idx_reg + 2'd1;
                if (({1'b0, step_idx_reg} + 3'd1) == steps_reg)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = out_valid_reg && !out_ready;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            steps_reg     <= '0;
            step_idx_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            steps_reg     <= steps_next;
            step_idx_reg  <= step_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

`ifndef SYNTHESIS
    a_step_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_STEP) |-> ({1'b0, step_idx_reg} < steps_reg))
        else $error("byte step index beyond the item's step count");

    a_no_step_item: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && (status.item_steps == 3'd0)) |=> (state_reg == S_FIN))
        else $error("item without byte steps did not go straight to finish");

    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |=> out_valid_reg)
        else $error("loaded result not presented");

    a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> (!out_valid_reg && !in_ready))
        else $error("item activity during the clearing pass");
`endif

endmodule

`default_nettype wire

@@ design/pcab_datapath.sv @@
`default_nettype none

module pcab_datapath #(
    parameter int NUM_SLOTS = 4
) (
    input  wire logic                                                   clk,
    input  wire logic                                                   rst_n,
    input  wire pcab_pkg::dp_cmd_t                                      cmd,
    output pcab_pkg::dp_status_t                                        status,
    input  wire pcab_pkg::in_item_t                                     in_data,
    input  wire logic [pcab_pkg::MAX_SLOTS-1:0][pcab_pkg::BDF_W-1:0]    slot_bdf,
    input  wire logic [pcab_pkg::MAX_SLOTS-1:0]                         slot_present,
    output pcab_pkg::out_item_t                                         out_data
);

    import pcab_pkg::*;

    localparam int DEPTH  = NUM_SLOTS * SPACE_BYTES;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

    in_item_t          item_reg;
    logic              err_reg;
    logic [31:0]       latch_reg;
    logic [31:0]       latch_next;
    logic [31:0]       acc_reg;
    logic [31:0]       acc_merged;
    logic [ADDR_W-1:0] clr_cnt_reg;
    logic              cap_valid_reg;
    logic              cap_valid_next;
    logic              cap_ram_reg;
    logic              cap_ram_next;
    logic [7:0]        cap_byte_reg;
    logic [7:0]        cap_byte_next;
    logic [1:0]        cap_idx_reg;
    out_item_t         out_reg;

    logic [2:0]        in_bytes;
    logic              in_host;
    logic              in_err;

    logic [2:0]        step_port;
    logic [1:0]        lane;
    logic [7:0]        wbyte;
    logic [15:0]       latch_bdf;
    logic              hit;
    logic [SLOT_W-1:0] hit_slot;
    logic              store_ok;

    logic              ram_we;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_addr;
    logic [7:0]        ram_wdata;
    logic [7:0]        ram_rdata;

    // Decode of the item at the input, so the controller knows its step count.
    always_comb
    begin
        status.clear_last = (clr_cnt_reg == ADDR_W'(DEPTH - 1));
        case (in_data.access_size)
            SIZE_BYTE: in_bytes = 3'd1;
            SIZE_WORD: in_bytes = 3'd2;
            default:   in_bytes = 3'd4;
        endcase
        in_host = (in_data.cmd == CMD_READ) || (in_data.cmd == CMD_WRITE);
        in_err  = in_host && (({1'b0, in_data.port_offset} + {1'b0, in_bytes}) > 4'd8);
        if (in_data.cmd == CMD_STORE)
        begin
            status.item_steps = 3'd1;
        end
        else if (in_host && !in_err)
        begin
            status.item_steps = in_bytes;
        end
        else
        begin
            status.item_steps = 3'd0;
        end
    end

    // Slot lookup on the current latch; the lowest matching present slot wins.
    always_comb
    begin
        latch_bdf = {latch_reg[23:16], latch_reg[15:11], latch_reg[10:8]};
        hit       = 1'b0;
        hit_slot  = '0;
        for (int s = NUM_SLOTS - 1; s >= 0; s--)
        begin
            if (slot_present[s] && ({7'd0, slot_bdf[s]} == latch_bdf))
            begin
                hit      = 1'b1;
                hit_slot = SLOT_W'(s);
            end
        end
        hit = hit && latch_reg[31];
    end

    assign step_port = item_reg.port_offset + {1'b0, cmd.step_idx};
    assign lane      = step_port[1:0];
    assign wbyte     = item_reg.write_data[{cmd.step_idx, 3'b000} +: 8];
    assign store_ok  = int'(item_reg.store_slot) < NUM_SLOTS;

    always_comb
    begin
        logic [31:0] merged;
        merged         = latch_reg;
        latch_next     = latch_reg;
        ram_we         = 1'b0;
        ram_re         = 1'b0;
        ram_addr       = clr_cnt_reg;
        ram_wdata      = 8'h00;
        cap_valid_next = 1'b0;
        cap_ram_next   = 1'b0;
        cap_byte_next  = 8'hFF;
        if (cmd.clear)
        begin
            ram_we = 1'b1;
        end
        else if (cmd.step)
        begin
            if (item_reg.cmd == CMD_STORE)
            begin
                ram_we    = store_ok;
                ram_addr  = ADDR_W'({item_reg.store_slot[SLOT_W-1:0], item_reg.store_offset});
                ram_wdata = item_reg.write_data[7:0];
            end
            else if (!step_port[2])
            begin
                if (item_reg.cmd == CMD_WRITE)
                begin
                    merged[{lane, 3'b000} +: 8] = wbyte;
                    latch_next = merged & ~RESERVED_ADDR_BITS;
                end
                else
                begin
                    cap_valid_next = 1'b1;
                    cap_byte_next  = latch_reg[{lane, 3'b000} +: 8];
                end
            end
            else
            begin
                ram_addr  = ADDR_W'({hit_slot, latch_reg[7:2], lane});
                ram_wdata = wbyte;
                if (item_reg.cmd == CMD_WRITE)
                begin
                    ram_we = hit;
                end
                else
                begin
                    // A miss reads as all ones without touching the store.
                    cap_valid_next = 1'b1;
                    cap_ram_next   = hit;
                    ram_re         = hit;
                end
            end
        end
    end

    // Read bytes land in the cycle after their step, when the store data is out.
    always_comb
    begin
        acc_merged = acc_reg;
        if (cap_valid_reg)
        begin
            acc_merged[{cap_idx_reg, 3'b000} +: 8] = cap_ram_reg ? ram_rdata : cap_byte_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            latch_reg     <= '0;
            clr_cnt_reg   <= '0;
            cap_valid_reg <= 1'b0;
            cap_ram_reg   <= 1'b0;
        end
        else
        begin
            latch_reg     <= latch_next;
            cap_valid_reg <= cap_valid_next;
            cap_ram_reg   <= cap_ram_next;
            if (cmd.clear)
            begin
                clr_cnt_reg <= clr_cnt_reg + ADDR_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cap_byte_reg <= cap_byte_next;
        cap_idx_reg  <= cmd.step_idx;
        if (cmd.load_item)
        begin
            item_reg <= in_data;
            err_reg  <= in_err;
            acc_reg  <= (in_err && (in_data.cmd == CMD_READ)) ? 32'hFFFF_FFFF : 32'h0;
        end
        else
        begin
            acc_reg <= acc_merged;
        end
        if (cmd.load_out)
        begin
            out_reg.read_data   <= acc_merged;
            out_reg.range_error <= err_reg;
        end
    end

    assign out_data = out_reg;

    pcab_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .en    (ram_we || ram_re),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

endmodule

`default_nettype wire

@@ design/pci_config_access_bridge.sv @@
`default_nettype none
// Flow: an item with n byte steps (1, 2 or 4 for host accesses, 1 for a device store)
// runs its steps, then a finish state loads its result once the output is free; a
// rejected or ignored item goes straight to finish. A new item is taken only after
// the load. Byte steps run one a cycle on the byte-wide configuration store and its
// registered read port. Reset: the latch and registers clear at once, then a clearing
// pass zeroes the store; no item is accepted until it ends, register writes are taken.

module pci_config_access_bridge #(
    parameter int NUM_SLOTS = 4
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire pcab_pkg::in_item_t            in_data,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output pcab_pkg::out_item_t                out_data,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [pcab_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [pcab_pkg::PDATA_W-1:0]  pwdata,
    output logic      [pcab_pkg::PDATA_W-1:0]  prdata,
    output logic                               pready
);

    import pcab_pkg::*;

    logic [MAX_SLOTS-1:0][BDF_W-1:0] slot_bdf_reg;
    logic [MAX_SLOTS-1:0]            slot_present_reg;
    logic [2:0]                      reg_idx;
    dp_cmd_t                         cmd;
    dp_status_t                      status;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_bdf_reg     <= '0;
            slot_present_reg <= '0;
        end
        else if (psel && penable && pwrite)
        begin
            case (reg_idx)
                REG_SLOT0_BDF:    slot_bdf_reg[0]  <= pwdata[BDF_W-1:0];
                REG_SLOT1_BDF:    slot_bdf_reg[1]  <= pwdata[BDF_W-1:0];
                REG_SLOT2_BDF:    slot_bdf_reg[2]  <= pwdata[BDF_W-1:0];
                REG_SLOT3_BDF:    slot_bdf_reg[3]  <= pwdata[BDF_W-1:0];
                REG_SLOT_PRESENT: slot_present_reg <= pwdata[MAX_SLOTS-1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_SLOT0_BDF:    prdata = PDATA_W'(slot_bdf_reg[0]);
            REG_SLOT1_BDF:    prdata = PDATA_W'(slot_bdf_reg[1]);
            REG_SLOT2_BDF:    prdata = PDATA_W'(slot_bdf_reg[2]);
            REG_SLOT3_BDF:    prdata = PDATA_W'(slot_bdf_reg[3]);
            REG_SLOT_PRESENT: prdata = PDATA_W'(slot_present_reg);
            default:          prdata = '0;
        endcase
    end

    pcab_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .status    (status)
    );

    pcab_datapath #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .in_data      (in_data),
        .slot_bdf     (slot_bdf_reg),
        .slot_present (slot_present_reg),
        .out_data     (out_data)
    );

endmodule

`default_nettype wire

@@ verif/pci_config_access_bridge_test.sv @@
`timescale 1ns / 1ps

module pci_config_access_bridge_test;

    import pcab_pkg::*;

    localparam int NUM_SLOTS      = 4;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int HOLD_CYCLES    = 300;

    // Codes the package leaves unnamed.
    localparam logic [1:0] CMD_NONE   = 2'd3;
    localparam logic [1:0] SIZE_DWORD = 2'd2;
    localparam logic [1:0] SIZE_ODD   = 2'd3;

    logic clk;
    logic rst_n = 1'b0;

    logic      in_valid = 1'b0;
    logic      in_ready;
    in_item_t  in_data  = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    out_item_t out_data;

    logic                 psel    = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite  = 1'b0;
    logic [PADDR_W-1:0]   paddr   = '0;
    logic [PDATA_W-1:0]   pwdata  = '0;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;

    pci_config_access_bridge #(
        .NUM_SLOTS(NUM_SLOTS)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data (out_data),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Shadow of the bridge state.
    logic [31:0]     addr_latch;
    logic            cyc_en;
    logic [7:0]      cfg_mem [0:MAX_SLOTS*SPACE_BYTES-1];
    logic [BDF_W-1:0] slot_bdf [0:MAX_SLOTS-1];
    logic [3:0]      slot_mask;

    typedef struct {
        in_item_t  item;
        bit        typed;
        out_item_t want;
    } dir_row_t;

    dir_row_t  dir_tab[$];
    out_item_t due_results[$];
    out_item_t due_head;
    int        errors      = 0;
    int        items_sent  = 0;
    int        idle_cycles = 0;
    bit        steady      = 1'b0;
    bit        hold_req    = 1'b0;
    bit        hold_asked  = 1'b0;

    function automatic int matching_slot();
        int s;
        for (s = 0; s < NUM_SLOTS; s++)
        begin
            if (slot_mask[s] && {7'd0, slot_bdf[s]} == addr_latch[23:8])
                return s;
        end
        return -1;
    endfunction

    function automatic logic [7:0] port_byte_read(input int port);
        int s;
        logic [1:0] lane;
        lane = port[1:0];
        if (port < 4)
            return addr_latch[8*lane +: 8];
        if (!cyc_en)
            return 8'hFF;
        s = matching_slot();
        if (s < 0)
            return 8'hFF;
        return cfg_mem[s*SPACE_BYTES + int'({addr_latch[7:2], lane})];
    endfunction

    function automatic void port_byte_write(input int port, input logic [7:0] b);
        int s;
        logic [1:0] lane;
        lane = port[1:0];
        if (port < 4)
        begin
            addr_latch[8*lane +: 8] = b;
            addr_latch = addr_latch & ~RESERVED_ADDR_BITS;
            cyc_en = addr_latch[31];
        end
        else if (cyc_en)
        begin
            s = matching_slot();
            if (s >= 0)
                cfg_mem[s*SPACE_BYTES + int'({addr_latch[7:2], lane})] = b;
        end
    endfunction

    function automatic int access_bytes(input logic [1:0] size);
        return (size == SIZE_BYTE) ? 1 : (size == SIZE_WORD) ? 2 : 4;
    endfunction

    // Applies one item to the shadow state and returns the result it must give.
    function automatic out_item_t bridge_access_result(input in_item_t it);
        out_item_t r;
        int n;
        int i;
        r = '0;
        n = access_bytes(it.access_size);
        if (it.cmd == CMD_STORE)
        begin
            if (int'(it.store_slot) < NUM_SLOTS)
                cfg_mem[int'({it.store_slot, it.store_offset})] = it.write_data[7:0];
        end
        else if (it.cmd == CMD_READ || it.cmd == CMD_WRITE)
        begin
            if (int'(it.port_offset) + n > 8)
            begin
                r.range_error = 1'b1;
                if (it.cmd == CMD_READ)
                    r.read_data = '1;
            end
            else
            begin
                for (i = 0; i < n; i++)
                begin
                    if (it.cmd == CMD_READ)
                        r.read_data[8*i +: 8] = port_byte_read(int'(it.port_offset) + i);
                    else
                        port_byte_write(int'(it.port_offset) + i, it.write_data[8*i +: 8]);
                end
            end
        end
        return r;
    endfunction

    function automatic void add_row(input logic [1:0] cmd, input logic [2:0] port,
                                    input logic [1:0] size, input logic [31:0] data,
                                    input logic [1:0] slot, input logic [7:0] off,
                                    input bit typed = 1'b0, input logic [31:0] rd = '0,
                                    input logic err = 1'b0);
        dir_row_t row;
        row.item  = '{cmd, port, size, data, slot, off};
        row.typed = typed;
        row.want  = '{rd, err};
        dir_tab.push_back(row);
    endfunction

    function automatic in_item_t rand_item();
        in_item_t it;
        it.cmd          = 2'($urandom_range(3));
        it.port_offset  = 3'($urandom_range(7));
        it.access_size  = 2'($urandom_range(3));
        it.write_data   = $urandom;
        it.store_slot   = 2'($urandom_range(3));
        it.store_offset = 8'($urandom_range(255));
        return it;
    endfunction

    // Both the register write and the shadow update happen on the access edge.
    task automatic cfg_write(input logic [2:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        case (idx)
            REG_SLOT0_BDF:    slot_bdf[0] = val[BDF_W-1:0];
            REG_SLOT1_BDF:    slot_bdf[1] = val[BDF_W-1:0];
            REG_SLOT2_BDF:    slot_bdf[2] = val[BDF_W-1:0];
            REG_SLOT3_BDF:    slot_bdf[3] = val[BDF_W-1:0];
            REG_SLOT_PRESENT: slot_mask   = val[3:0];
            default:          ;
        endcase
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
    endtask

    task automatic set_slots(input logic [8:0] b0, input logic [8:0] b1,
                             input logic [8:0] b2, input logic [8:0] b3,
                             input logic [3:0] mask);
        cfg_write(REG_SLOT0_BDF, 32'(b0));
        cfg_write(REG_SLOT1_BDF, 32'(b1));
        cfg_write(REG_SLOT2_BDF, 32'(b2));
        cfg_write(REG_SLOT3_BDF, 32'(b3));
        cfg_write(REG_SLOT_PRESENT, 32'(mask));
    endtask

    // Entered and left at a falling edge; valid stays high into the next call.
    task automatic send_item(input in_item_t it, input bit typed = 1'b0,
                             input out_item_t want = '0);
        out_item_t got;
        if (!steady)
        begin
            while ($urandom_range(99) < 38)
            begin
                in_valid <= 1'b0;
                @(negedge clk);
            end
        end
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        got = bridge_access_result(it);
        due_results.push_back(typed ? want : got);
        if (it.cmd != CMD_NONE)
            items_sent++;
        steady = (items_sent >= 250 && items_sent < 400);
        if (items_sent == 500 && !hold_asked)
        begin
            hold_req   = 1'b1;
            hold_asked = 1'b1;
        end
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (due_results.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    // Mostly address set-up followed by data port traffic, with device stores and noise.
    task automatic run_random(input int count);
        int goal;
        int k;
        int n;
        int pick;
        in_item_t it;
        logic [8:0] bdf;
        logic [7:0] bus;
        logic [31:0] adr;
        goal = items_sent + count;
        while (items_sent < goal)
        begin
            pick = $urandom_range(99);
            if (pick < 65)
            begin
                bdf = slot_bdf[$urandom_range(MAX_SLOTS-1)];
                bus = ($urandom_range(9) == 0) ? 8'($urandom) : {7'd0, bdf[8]};
                adr = {($urandom_range(9) != 0), 7'($urandom), bus, bdf[7:0], 8'($urandom)};
                it = rand_item();
                it.cmd = CMD_WRITE;
                if ($urandom_range(3) == 0)
                begin
                    it.port_offset = 3'd0;
                    it.access_size = SIZE_WORD;
                    it.write_data[15:0] = adr[15:0];
                    send_item(it);
                    it = rand_item();
                    it.cmd = CMD_WRITE;
                    it.port_offset = 3'd2;
                    it.access_size = SIZE_WORD;
                    it.write_data[15:0] = adr[31:16];
                end
                else
                begin
                    it.port_offset = 3'd0;
                    it.access_size = SIZE_DWORD;
                    it.write_data = adr;
                end
                send_item(it);
                for (k = 0; k < int'($urandom_range(4, 1)); k++)
                begin
                    it = rand_item();
                    if ($urandom_range(7) == 0)
                    begin
                        it.cmd = CMD_STORE;
                        if ($urandom_range(1) == 0)
                            it.store_offset = {addr_latch[7:2], 2'($urandom_range(3))};
                    end
                    else
                    begin
                        it.cmd = ($urandom_range(1) == 0) ? CMD_READ : CMD_WRITE;
                        n = access_bytes(it.access_size);
                        it.port_offset = 3'(4 + $urandom_range(4 - n));
                    end
                    send_item(it);
                end
            end
            else if (pick < 80)
            begin
                it = rand_item();
                it.cmd = CMD_STORE;
                send_item(it);
            end
            else
                send_item(rand_item());
        end
    endtask

    initial
    begin
        int k;
        logic [8:0] b;

        addr_latch = '0;
        cyc_en     = 1'b0;
        slot_mask  = '0;
        for (k = 0; k < MAX_SLOTS; k++)
            slot_bdf[k] = '0;
        for (k = 0; k < MAX_SLOTS*SPACE_BYTES; k++)
            cfg_mem[k] = '0;

        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Slots 2 and 3 share one function number; slot 2 must win.
        set_slots(9'h000, 9'h1FF, 9'h0A3, 9'h0A3, 4'hF);

        add_row(CMD_READ,  3'd0, SIZE_DWORD, 32'h0, 2'd0, 8'h00, 1, 32'h0000_0000, 0);
        add_row(CMD_READ,  3'd4, SIZE_DWORD, 32'h0, 2'd0, 8'h00, 1, 32'hFFFF_FFFF, 0);
        add_row(CMD_READ,  3'd7, SIZE_BYTE,  32'h0, 2'd0, 8'h00, 1, 32'h0000_00FF, 0);
        add_row(CMD_READ,  3'd5, SIZE_DWORD, 32'h0, 2'd0, 8'h00, 1, 32'hFFFF_FFFF, 1);
        add_row(CMD_WRITE, 3'd7, SIZE_WORD,  32'hFFFF_FFFF, 2'd0, 8'h00, 1, 32'h0, 1);
        add_row(CMD_STORE, 3'd0, SIZE_BYTE,  32'h0000_005A, 2'd2, 8'h10, 1, 32'h0, 0);
        add_row(CMD_STORE, 3'd0, SIZE_BYTE,  32'h0000_00C3, 2'd3, 8'h10, 1, 32'h0, 0);
        add_row(CMD_STORE, 3'd0, SIZE_BYTE,  32'hFFFF_FFFF, 2'd0, 8'h00, 1, 32'h0, 0);
        add_row(CMD_WRITE, 3'd0, SIZE_DWORD, 32'h7F00_A313, 2'd0, 8'h00, 1, 32'h0, 0);
        add_row(CMD_READ,  3'd4, SIZE_DWORD, 32'h0, 2'd0, 8'h00, 1, 32'hFFFF_FFFF, 0);
        add_row(CMD_WRITE, 3'd3, SIZE_BYTE,  32'h0000_0080, 2'd0, 8'h00, 1, 32'h0, 0);
        add_row(CMD_READ,  3'd0, SIZE_DWORD, 32'h0, 2'd0, 8'h00);
        add_row(CMD_READ,  3'd4, SIZE_DWORD, 32'h0, 2'd0, 8'h00);
        add_row(CMD_WRITE, 3'd4, SIZE_DWORD, 32'h1234_5678, 2'd0, 8'h00, 1, 32'h0, 0);
        add_row(CMD_READ,  3'd5, SIZE_WORD,  32'h0, 2'd0, 8'h00);
        // Crosses from the address port into the data port.
        add_row(CMD_WRITE, 3'd2, SIZE_DWORD, 32'hEEDD_8000, 2'd0, 8'h00, 1, 32'h0, 0);
        add_row(CMD_READ,  3'd4, SIZE_DWORD, 32'h0, 2'd0, 8'h00);
        add_row(CMD_WRITE, 3'd0, SIZE_DWORD, 32'hFFFF_FFFF, 2'd0, 8'h00, 1, 32'h0, 0);
        add_row(CMD_READ,  3'd0, SIZE_DWORD, 32'h0, 2'd0, 8'h00, 1, 32'h80FF_FFFC, 0);
        add_row(CMD_READ,  3'd4, SIZE_DWORD, 32'h0, 2'd0, 8'h00, 1, 32'hFFFF_FFFF, 0);
        add_row(CMD_WRITE, 3'd0, SIZE_DWORD, 32'h8001_FFFC, 2'd0, 8'h00, 1, 32'h0, 0);
        add_row(CMD_WRITE, 3'd4, SIZE_DWORD, 32'hFFFF_FFFF, 2'd0, 8'h00, 1, 32'h0, 0);
        add_row(CMD_READ,  3'd4, SIZE_ODD,   32'h0, 2'd0, 8'h00);
        add_row(CMD_WRITE, 3'd0, SIZE_DWORD, 32'h8000_0000, 2'd0, 8'h00, 1, 32'h0, 0);
        add_row(CMD_READ,  3'd4, SIZE_BYTE,  32'h0, 2'd0, 8'h00);
        add_row(CMD_NONE,  3'd7, SIZE_ODD,   32'hFFFF_FFFF, 2'd3, 8'hFF, 1, 32'h0, 0);

        for (k = 0; k < dir_tab.size(); k++)
            send_item(dir_tab[k].item, dir_tab[k].typed, dir_tab[k].want);
        drain();

        set_slots(9'($urandom), 9'($urandom), 9'($urandom), 9'($urandom), 4'hF);
        run_random(200);
        drain();

        // Nothing present: every data port byte must read as all ones.
        set_slots(9'h1FF, 9'h1FF, 9'h1FF, 9'h1FF, 4'h0);
        run_random(150);
        drain();

        set_slots(9'($urandom), 9'($urandom), 9'($urandom), 9'($urandom), 4'($urandom));
        run_random(200);
        drain();

        b = 9'($urandom);
        set_slots(9'h000, b, b, 9'h1FF, 4'hF);
        run_random(200);
        drain();

        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Result side: random back-pressure, one long hold-off on request.
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            else
                out_ready <= steady || ($urandom_range(99) >= 38);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (due_results.size() == 0)
            begin
                $display("%0t: unexpected result item %h", $time, out_data);
                errors++;
            end
            else
            begin
                due_head = due_results.pop_front();
                if (out_data.read_data !== due_head.read_data)
                begin
                    $display("%0t: read_data expected %h got %h",
                             $time, due_head.read_data, out_data.read_data);
                    errors++;
                end
                if (out_data.range_error !== due_head.range_error)
                begin
                    $display("%0t: range_error expected %b got %b",
                             $time, due_head.range_error, out_data.range_error);
                    errors++;
                end
            end
        end
    end

    // The clearing pass after reset and the hold-off both stay well inside the limit.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == WATCHDOG_LIMIT)
        begin
            $display("%0t: no item moved for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("TB_ERROR");
            $finish;
        end
    end

endmodule
